@@ rtl/epf_pkg.sv @@
// ----------------------------------------------------------------------------
// epf_pkg: shared types and constants of the escaped packet framer
// Item structs, configuration layout, job descriptor and line encoding helpers.
// ----------------------------------------------------------------------------
package epf_pkg;

  localparam logic [7:0] HDR_SYNC = 8'hF0;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] HDR_DATA = 8'h01;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PING   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_CLOSE  = 3'd2,
    KIND_MASTER = 3'd3,
    KIND_WRITE  = 3'd4
  } kind_t;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_BLOCK = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    CFG_CODE_PING         = 3'd0,
    CFG_CODE_CREATE       = 3'd1,
    CFG_CODE_CLOSE        = 3'd2,
    CFG_CODE_MASTER_FIRST = 3'd3,
    CFG_CODE_MASTER_NEXT  = 3'd4,
    CFG_CODE_WRITE        = 3'd5,
    CFG_TERM_LAST         = 3'd6,
    CFG_TERM_MORE         = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] code_ping;
    logic [7:0] code_create;
    logic [7:0] code_close;
    logic [7:0] code_master_first;
    logic [7:0] code_master_next;
    logic [7:0] code_write;
    logic [7:0] term_last;
    logic [7:0] term_more;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  kind;
    logic [7:0]  src_addr;
    logic [7:0]  dst_addr;
    logic [15:0] total_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Output segments, sent in this order when enabled in a job's mask.
  typedef enum logic [2:0] {
    SEG_DATA  = 3'd0,   // escaped payload byte
    SEG_SUMA  = 3'd1,   // escaped sum closing the current block
    SEG_TERMA = 3'd2,   // terminator after that sum
    SEG_HDR   = 3'd3,   // five-byte header
    SEG_CODE  = 3'd4,   // escaped command
    SEG_LEN   = 3'd5,   // escaped length
    SEG_SUMB  = 3'd6,   // escaped sum of an empty block
    SEG_TERMB = 3'd7    // terminator after header or empty block
  } seg_t;

  localparam int SEG_N = 8;

  typedef struct packed {
    logic [SEG_N-1:0] mask;
    logic [7:0]       data;
    logic [15:0]      sum;
    logic [7:0]       term;
    logic [7:0]       dst;
    logic [7:0]       code3;
    logic [7:0]       src;
    logic [7:0]       code;
    logic [15:0]      len;
  } job_t;

  function automatic logic [2:0] seg_len(seg_t s);
    logic [2:0] n;
    n = 3'd1;
    unique case (s) inside
      SEG_DATA, SEG_CODE:            n = 3'd2;
      SEG_SUMA, SEG_SUMB, SEG_LEN:   n = 3'd4;
      SEG_TERMA, SEG_TERMB:          n = 3'd1;
      SEG_HDR:                       n = 3'd5;
      default:                       n = 3'd1;
    endcase
    return n;
  endfunction

  // Escaped form: top bit first, then the low seven bits.
  function automatic logic [7:0] esc_byte(logic [7:0] b, logic hi);
    return hi ? {7'd0, b[7]} : {1'b0, b[6:0]};
  endfunction

  // Escaped 16-bit word, high byte first; idx picks one of four line bytes.
  function automatic logic [7:0] esc_word(logic [15:0] w, logic [1:0] idx);
    return esc_byte(idx[1] ? w[7:0] : w[15:8], ~idx[0]);
  endfunction

endpackage

@@ rtl/escaped_packet_framer_top.sv @@
// ----------------------------------------------------------------------------
// escaped_packet_framer_top: serial station link packet framer
// Turns start and payload items into escaped line bytes, one byte per transfer.
// ----------------------------------------------------------------------------
// Rate and flow: the line side sends one byte per cycle unless out_ready
// stalls it. An item causes 2 line bytes for a payload byte, 7 when it also
// closes a block, 18 when it closes a master chunk and opens the next; 6 for
// a ping start, 11 for another start, 16 for a start with zero length. The
// output byte sequencer thus sets the sustained payload rate. The front end
// keeps all packet state and hands one job per item with output to a
// two-entry queue, so it takes the next item while the sequencer is still
// sending; items that cause nothing (stray payload, unknown kind) are taken
// at once whenever the queue has room. When the sequencer is idle, the first
// line byte passes the job queue and the registered output stage before it
// is offered. The last byte of each item's output carries run_last.
// Registers are written through the plain cfg port; the user must write them
// only while nothing is in flight, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module escaped_packet_framer_top import epf_pkg::*; #(
  parameter int CHUNK_BYTES = 56
) (
  input  logic       clk,
  input  logic       rst,
  // input item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  // line byte channel
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  // register write port
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;
  logic job_valid;
  logic q_full;
  job_t job;
  logic head_valid;
  job_t head;
  logic pop;

  // Code and terminator registers, reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_CODE_PING:         cfg.code_ping         <= cfg_data;
        CFG_CODE_CREATE:       cfg.code_create       <= cfg_data;
        CFG_CODE_CLOSE:        cfg.code_close        <= cfg_data;
        CFG_CODE_MASTER_FIRST: cfg.code_master_first <= cfg_data;
        CFG_CODE_MASTER_NEXT:  cfg.code_master_next  <= cfg_data;
        CFG_CODE_WRITE:        cfg.code_write        <= cfg_data;
        CFG_TERM_LAST:         cfg.term_last         <= cfg_data;
        default:               cfg.term_more         <= cfg_data;
      endcase
    end
  end

  // Front end: accepts items, keeps block/chunk counts and the running sum.
  epf_front #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_valid(job_valid),
    .job_ready(~q_full),
    .job      (job)
  );

  // Job queue decouples item intake from byte output.
  epf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  // Back end: serializes the head job through a registered output stage.
  epf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/epf_front.sv @@
// ----------------------------------------------------------------------------
// epf_front: item acceptance and packet bookkeeping
// Tracks block state per input item and emits one job per item with output.
// ----------------------------------------------------------------------------
module epf_front import epf_pkg::*; #(
  parameter int CHUNK_BYTES = 56
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  localparam int          CL_W      = $clog2(CHUNK_BYTES + 1);
  localparam logic [15:0] CHUNK_LEN = 16'(CHUNK_BYTES);

  phase_t          phase, phase_next;
  logic            is_master, is_master_next;
  logic [7:0]      src_hold, src_hold_next;
  logic [7:0]      dst_hold, dst_hold_next;
  logic [15:0]     rem, rem_next;
  logic [CL_W-1:0] chunk_left, chunk_left_next;
  logic [15:0]     run_sum, run_sum_next;

  logic            accept;
  logic [15:0]     start_len;
  logic [15:0]     sum_new;
  logic [15:0]     rem_dec;
  logic [15:0]     next_len;
  logic [CL_W-1:0] cl_dec;
  logic            done;

  assign in_ready = job_ready;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      is_master  <= 1'b0;
      src_hold   <= '0;
      dst_hold   <= '0;
      rem        <= '0;
      chunk_left <= '0;
      run_sum    <= '0;
    end else begin
      phase      <= phase_next;
      is_master  <= is_master_next;
      src_hold   <= src_hold_next;
      dst_hold   <= dst_hold_next;
      rem        <= rem_next;
      chunk_left <= chunk_left_next;
      run_sum    <= run_sum_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    is_master_next  = is_master;
    src_hold_next   = src_hold;
    dst_hold_next   = dst_hold;
    rem_next        = rem;
    chunk_left_next = chunk_left;
    run_sum_next    = run_sum;
    job             = '0;

    start_len = (in_data.total_len > CHUNK_LEN) ? CHUNK_LEN : in_data.total_len;
    sum_new   = run_sum + 16'(in_data.data_byte);
    rem_dec   = rem - 16'(rem != 16'd0);
    cl_dec    = chunk_left - CL_W'(chunk_left != '0);
    next_len  = (rem_dec > CHUNK_LEN) ? CHUNK_LEN : rem_dec;
    done      = is_master ? (cl_dec == '0) : (rem_dec == 16'd0);

    if (accept) begin
      if (in_data.cmd == CMD_START) begin
        phase_next      = PH_IDLE;
        is_master_next  = (in_data.kind == KIND_MASTER);
        src_hold_next   = in_data.src_addr;
        dst_hold_next   = in_data.dst_addr;
        rem_next        = in_data.total_len;
        chunk_left_next = '0;
        run_sum_next    = '0;
        job.dst         = in_data.dst_addr;
        job.src         = in_data.src_addr;
        job.code3       = HDR_DATA;
        job.len         = in_data.total_len;
        job.term        = cfg.term_last;
        case (in_data.kind) inside
          KIND_PING: begin
            job.code3           = cfg.code_ping;
            job.mask[SEG_HDR]   = 1'b1;
            job.mask[SEG_TERMB] = 1'b1;
          end
          KIND_CREATE, KIND_CLOSE, KIND_WRITE, KIND_MASTER: begin
            unique case (in_data.kind)
              KIND_CREATE: job.code = cfg.code_create;
              KIND_CLOSE:  job.code = cfg.code_close;
              KIND_WRITE:  job.code = cfg.code_write;
              default:     job.code = cfg.code_master_first;
            endcase
            if (in_data.kind == KIND_MASTER) begin
              job.len         = start_len;
              chunk_left_next = start_len[CL_W-1:0];
            end
            job.mask[SEG_HDR]  = 1'b1;
            job.mask[SEG_CODE] = 1'b1;
            job.mask[SEG_LEN]  = 1'b1;
            if (in_data.total_len == 16'd0) begin
              // empty block closes at once with a zero sum
              job.mask[SEG_SUMB]  = 1'b1;
              job.mask[SEG_TERMB] = 1'b1;
            end else begin
              phase_next = PH_BLOCK;
            end
          end
          default: ;  // unknown kind: nothing sent
        endcase
      end else if (phase == PH_BLOCK) begin
        job.data           = in_data.data_byte;
        job.mask[SEG_DATA] = 1'b1;
        run_sum_next       = sum_new;
        rem_next           = rem_dec;
        chunk_left_next    = cl_dec;
        if (done) begin
          job.sum             = sum_new;
          job.mask[SEG_SUMA]  = 1'b1;
          job.mask[SEG_TERMA] = 1'b1;
          if (is_master && rem_dec != 16'd0) begin
            // chunk hand-over: open the next chunk in the same job
            job.term           = cfg.term_more;
            job.dst            = dst_hold;
            job.src            = src_hold;
            job.code3          = HDR_DATA;
            job.code           = cfg.code_master_next;
            job.len            = next_len;
            job.mask[SEG_HDR]  = 1'b1;
            job.mask[SEG_CODE] = 1'b1;
            job.mask[SEG_LEN]  = 1'b1;
            chunk_left_next    = next_len[CL_W-1:0];
            run_sum_next       = '0;
          end else begin
            job.term   = cfg.term_last;
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  assign job_valid = accept & (job.mask != '0);

endmodule

@@ rtl/epf_queue.sv @@
// ----------------------------------------------------------------------------
// epf_queue: short job queue between front and back
// Register-based FIFO; head entry is read directly by the back end.
// ----------------------------------------------------------------------------
module epf_queue import epf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  output logic head_valid,
  output job_t head,
  input  logic pop
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/epf_back.sv @@
// ----------------------------------------------------------------------------
// epf_back: line byte sequencer
// Walks the head job's enabled segments, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module epf_back import epf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [SEG_N-1:0] done_mask;
  logic [2:0]       idx;
  logic [SEG_N-1:0] pending;
  logic [SEG_N-1:0] rest;
  seg_t             cur;
  logic             seg_end;
  logic             job_end;
  logic             advance;
  logic [7:0]       line_byte;

  always_comb begin
    pending = head.mask & ~done_mask;
    cur     = SEG_DATA;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (pending[i]) begin
        cur = seg_t'(3'(i));
      end
    end
    rest      = pending;
    rest[cur] = 1'b0;
  end

  assign seg_end = (idx == seg_len(cur) - 3'd1);
  assign job_end = seg_end & (rest == '0);
  assign advance = head_valid & (~out_valid | out_ready);
  assign pop     = advance & job_end;

  always_comb begin
    unique case (cur) inside
      SEG_DATA:             line_byte = esc_byte(head.data, ~idx[0]);
      SEG_SUMA, SEG_SUMB:   line_byte = esc_word(head.sum, idx[1:0]);
      SEG_TERMA, SEG_TERMB: line_byte = head.term;
      SEG_CODE:             line_byte = esc_byte(head.code, ~idx[0]);
      SEG_LEN:              line_byte = esc_word(head.len, idx[1:0]);
      SEG_HDR: begin
        case (idx)
          3'd0:    line_byte = HDR_SYNC;
          3'd1:    line_byte = HDR_ZERO;
          3'd2:    line_byte = head.dst;
          3'd3:    line_byte = head.code3;
          default: line_byte = head.src;
        endcase
      end
      default:              line_byte = head.term;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (seg_end) begin
          idx <= '0;
          if (job_end) begin
            done_mask <= '0;
          end else begin
            done_mask <= done_mask | (pending & ~rest);
          end
        end else begin
          idx <= idx + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_byte <= line_byte;
      out_data.run_last <= job_end;
    end
  end

endmodule
